### rtl/optb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// optb_pkg: shared types and constants of the timer bank
// Holds the item kinds, the slot states, the per-slot entry layout and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package optb_pkg;

  // default bank size and cap on expiry events per tick
  localparam int NumTimersDef = 16;
  localparam int MaxResults   = 16;

  localparam int SlotW  = 4;
  localparam int CountW = 32;

  // input item kinds
  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_SETUP = 3'd1,
    KIND_START = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_READ  = 3'd4
  } kind_e;

  // slot life cycle
  typedef enum logic [1:0] {
    TS_UNUSED  = 2'd0,
    TS_CREATED = 2'd1,
    TS_STARTED = 2'd2,
    TS_STOPPED = 2'd3
  } tstate_e;

  // result item kinds
  typedef enum logic {
    EV_EXPIRED = 1'b0,
    EV_INFO    = 1'b1
  } event_e;

  // controller states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_LOOKUP,
    CS_EXEC,
    CS_WALK_RD,
    CS_WALK,
    CS_FLUSH
  } ctrl_state_e;

  // one slot as kept in the slot memory
  typedef struct packed {
    logic [CountW-1:0] rem;
    logic [CountW-1:0] dly;
    logic [CountW-1:0] per;
    logic              hard;
    tstate_e           state;
  } entry_t;

  // one result item
  typedef struct packed {
    event_e            ev;
    logic [SlotW-1:0]  slot;
    logic              hard;
    tstate_e           state;
    logic [CountW-1:0] dly;
    logic [CountW-1:0] per;
    logic              last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup_rd;
    logic exec;
    logic walk_rd;
    logic walk_step;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exec_ok;
    logic walk_stall;
    logic proc_last;
    logic pass_hard;
    logic flush_done;
  } sts_t;

endpackage
`default_nettype wire

### rtl/optb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// optb_ctrl: sequencing of the timer bank
// Accepts input items, steps slot operations through lookup and execute, and
// runs a tick as a hard pass, a soft pass and a final flush of the last event.
// ----------------------------------------------------------------------------
module optb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire optb_pkg::kind_e     kind_i,
  output optb_pkg::cmd_t           cmd_o,
  input  wire optb_pkg::sts_t      sts_i
);

  optb_pkg::ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= optb_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      optb_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (kind_i) inside
            optb_pkg::KIND_TICK: state_d = optb_pkg::CS_WALK_RD;
            [optb_pkg::KIND_SETUP:optb_pkg::KIND_READ]: state_d = optb_pkg::CS_LOOKUP;
            default: state_d = optb_pkg::CS_IDLE;
          endcase
        end
      end
      optb_pkg::CS_LOOKUP: begin
        cmd_o.lookup_rd = 1'b1;
        state_d         = optb_pkg::CS_EXEC;
      end
      optb_pkg::CS_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.exec_ok) begin
          state_d = optb_pkg::CS_IDLE;
        end
      end
      optb_pkg::CS_WALK_RD: begin
        cmd_o.walk_rd = 1'b1;
        state_d       = optb_pkg::CS_WALK;
      end
      optb_pkg::CS_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (!sts_i.walk_stall && sts_i.proc_last) begin
          state_d = sts_i.pass_hard ? optb_pkg::CS_WALK_RD : optb_pkg::CS_FLUSH;
        end
      end
      optb_pkg::CS_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.flush_done) begin
          state_d = optb_pkg::CS_IDLE;
        end
      end
      default: state_d = optb_pkg::CS_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/optb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// optb_dp: slot memory and processing of the timer bank
// Keeps each slot in its own memory word with a valid bit per slot, applies
// setup, start and stop, walks the slots on a tick and holds the output item.
// ----------------------------------------------------------------------------
module optb_dp #(
  parameter int NumTimers = optb_pkg::NumTimersDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire optb_pkg::cmd_t              cmd_i,
  output optb_pkg::sts_t                   sts_o,
  input  wire optb_pkg::kind_e             kind_i,
  input  wire logic [optb_pkg::SlotW-1:0]  slot_i,
  input  wire logic [optb_pkg::CountW-1:0] dly_i,
  input  wire logic [optb_pkg::CountW-1:0] per_i,
  input  wire logic                        hard_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output optb_pkg::out_item_t              out_item_o
);

  localparam int IdxW = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW = $clog2(optb_pkg::MaxResults + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumTimers - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(optb_pkg::MaxResults);
  localparam logic [31:0]     SlotLim = 32'(NumTimers);

  // captured input item
  optb_pkg::kind_e             item_kind_q;
  logic [optb_pkg::SlotW-1:0]  item_slot_q;
  logic [optb_pkg::CountW-1:0] item_dly_q;
  logic [optb_pkg::CountW-1:0] item_per_q;
  logic                        item_hard_q;

  // slot memory with registered read
  optb_pkg::entry_t mem [NumTimers];
  logic [NumTimers-1:0] valid_q;
  optb_pkg::entry_t rdata_q;
  logic             rvalid_q;

  // walk state
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] proc_idx_q;
  logic            cls_q;
  logic [CntW-1:0] cnt_q;
  logic                pend_v_q;
  optb_pkg::out_item_t pend_q;

  // output register
  logic                out_v_q;
  optb_pkg::out_item_t out_q;

  logic                slot_ok;
  logic [IdxW-1:0]     slot_addr;
  optb_pkg::entry_t    ent;
  optb_pkg::entry_t    walk_ent;
  logic [optb_pkg::CountW-1:0] rem_dec;
  logic                hit;
  logic                expire;
  logic                report;
  logic                out_free;
  logic                walk_stall;
  logic                exec_ok;
  logic                proc_last;
  logic                walk_go;
  logic                rd_en;
  logic [IdxW-1:0]     raddr;
  logic                wr_en;
  logic [IdxW-1:0]     waddr;
  optb_pkg::entry_t    wdata;
  logic                out_load;
  optb_pkg::out_item_t out_din;
  optb_pkg::out_item_t walk_ev;

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_kind_q <= kind_i;
      item_slot_q <= slot_i;
      item_dly_q  <= dly_i;
      item_per_q  <= per_i;
      item_hard_q <= hard_i;
    end
  end

  assign slot_ok   = {{(32 - optb_pkg::SlotW){1'b0}}, item_slot_q} < SlotLim;
  assign slot_addr = IdxW'(item_slot_q);

  // slot read, a never written slot reads as zero
  assign ent = rvalid_q ? rdata_q : '0;

  // tick processing of the slot in rdata
  assign hit       = (ent.state == optb_pkg::TS_STARTED) && (ent.hard == cls_q);
  assign rem_dec   = ent.rem - 1'b1;
  assign expire    = (ent.rem == '0) || (rem_dec == '0);
  assign report    = hit && expire && (cnt_q < MaxCnt);
  assign out_free  = !out_v_q || out_ready_i;
  assign walk_stall = report && pend_v_q && !out_free;
  assign exec_ok   = (item_kind_q != optb_pkg::KIND_READ) || out_free;
  assign proc_last = (proc_idx_q == LastIdx);
  assign walk_go   = cmd_i.walk_step && !walk_stall;

  always_comb begin
    walk_ent     = ent;
    walk_ent.rem = expire ? ent.per : rem_dec;
    if (expire && (ent.per == '0)) begin
      walk_ent.state = optb_pkg::TS_STOPPED;
    end
    walk_ev       = '0;
    walk_ev.ev    = optb_pkg::EV_EXPIRED;
    walk_ev.slot  = optb_pkg::SlotW'(proc_idx_q);
    walk_ev.hard  = ent.hard;
    walk_ev.state = walk_ent.state;
  end

  // memory port and output load selection
  always_comb begin
    rd_en    = 1'b0;
    raddr    = slot_addr;
    wr_en    = 1'b0;
    waddr    = slot_addr;
    wdata    = ent;
    out_load = 1'b0;
    out_din  = pend_q;
    if (cmd_i.lookup_rd) begin
      rd_en = slot_ok;
    end
    if (cmd_i.exec && exec_ok) begin
      case (item_kind_q)
        optb_pkg::KIND_SETUP: begin
          wr_en       = slot_ok;
          wdata.rem   = (item_dly_q != '0) ? item_dly_q : item_per_q;
          wdata.dly   = item_dly_q;
          wdata.per   = item_per_q;
          wdata.hard  = item_hard_q;
          wdata.state = optb_pkg::TS_CREATED;
        end
        optb_pkg::KIND_START: begin
          wr_en       = slot_ok && ((ent.state == optb_pkg::TS_CREATED) ||
                                    (ent.state == optb_pkg::TS_STOPPED));
          wdata.rem   = (ent.dly != '0) ? ent.dly : ent.per;
          wdata.state = optb_pkg::TS_STARTED;
        end
        optb_pkg::KIND_STOP: begin
          wr_en       = slot_ok && (ent.state == optb_pkg::TS_STARTED);
          wdata.state = optb_pkg::TS_STOPPED;
        end
        optb_pkg::KIND_READ: begin
          out_load      = 1'b1;
          out_din.ev    = optb_pkg::EV_INFO;
          out_din.slot  = item_slot_q;
          out_din.hard  = slot_ok ? ent.hard : 1'b0;
          out_din.state = slot_ok ? ent.state : optb_pkg::TS_UNUSED;
          out_din.dly   = slot_ok ? ent.dly : '0;
          out_din.per   = slot_ok ? ent.per : '0;
          out_din.last  = 1'b1;
        end
        default: ;
      endcase
    end
    if (cmd_i.walk_rd) begin
      rd_en = 1'b1;
      raddr = idx_q;
    end
    if (walk_go) begin
      wr_en = hit;
      waddr = proc_idx_q;
      wdata = walk_ent;
      if (report && pend_v_q) begin
        out_load     = 1'b1;
        out_din      = pend_q;
        out_din.last = 1'b0;
      end
      if (!proc_last) begin
        rd_en = 1'b1;
        raddr = idx_q;
      end
    end
    if (cmd_i.flush && pend_v_q && out_free) begin
      out_load     = 1'b1;
      out_din      = pend_q;
      out_din.last = 1'b1;
    end
  end

  // slot memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q  <= mem[raddr];
      rvalid_q <= valid_q[raddr];
    end
  end

  // per-slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // walk counters and pending event
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      proc_idx_q <= '0;
      cls_q      <= 1'b1;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0;
        cls_q <= 1'b1;
        cnt_q <= '0;
      end
      if (cmd_i.walk_rd) begin
        proc_idx_q <= idx_q;
        idx_q      <= idx_q + 1'b1;
      end
      if (walk_go) begin
        if (proc_last) begin
          idx_q <= '0;
          cls_q <= ~cls_q;
        end else begin
          proc_idx_q <= idx_q;
          idx_q      <= idx_q + 1'b1;
        end
        if (report) begin
          cnt_q    <= cnt_q + 1'b1;
          pend_v_q <= 1'b1;
        end
      end
      if (cmd_i.flush && pend_v_q && out_free) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_go && report) begin
      pend_q <= walk_ev;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_din;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  // status to the controller
  assign sts_o.exec_ok    = exec_ok;
  assign sts_o.walk_stall = walk_stall;
  assign sts_o.proc_last  = proc_last;
  assign sts_o.pass_hard  = cls_q;
  assign sts_o.flush_done = !pend_v_q || out_free;

endmodule
`default_nettype wire

### rtl/oneshot_periodic_timer_bank.sv
`default_nettype none
// Setup, start and stop go from acceptance through lookup and execute back to idle;
// a read result is loaded into the output register in execute once the output is free.
// A tick runs a hard and then a soft pass, each a read lead-in and then one slot per
// cycle while the output does not stall, followed by a final flush and the return to idle.
// One item is in work at a time; output stalls hold the walk and the flush.
// Reset clears the control state and the per-slot valid bits, so slots read as zero.
// ----------------------------------------------------------------------------
// oneshot_periodic_timer_bank: bank of one-shot and periodic timer slots
// Streaming item in, expiry and info items out, with a slot memory walked
// once per class on every tick.
// ----------------------------------------------------------------------------
module oneshot_periodic_timer_bank #(
  parameter int NumTimers = optb_pkg::NumTimersDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // slot[3:0], start_delay[35:4], period[67:36], hard_type[68], zero[71:69]
  input  wire logic [71:0] s_axis_tdata,
  // kind[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // slot_out[3:0], hard_out[4], timer_state[6:5], start_delay_out[38:7],
  // period_out[70:39], zero[71]
  output logic [71:0]      m_axis_tdata,
  // event_res[0]
  output logic [0:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  optb_pkg::cmd_t      cmd;
  optb_pkg::sts_t      sts;
  optb_pkg::kind_e     in_kind;
  optb_pkg::out_item_t out_item;

  assign in_kind = optb_pkg::kind_e'(s_axis_tuser);

  // sequencing
  optb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .kind_i     (in_kind),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // slot memory and processing
  optb_dp #(
    .NumTimers (NumTimers)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (in_kind),
    .slot_i      (s_axis_tdata[3:0]),
    .dly_i       (s_axis_tdata[35:4]),
    .per_i       (s_axis_tdata[67:36]),
    .hard_i      (s_axis_tdata[68]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item)
  );

  // output packing
  assign m_axis_tdata = {1'b0, out_item.per, out_item.dly, out_item.state,
                         out_item.hard, out_item.slot};
  assign m_axis_tuser = out_item.ev;
  assign m_axis_tlast = out_item.last;

endmodule
`default_nettype wire
